// ----- design/ssd_pkg.sv -----
package ssd_pkg;

    localparam int NumDigits = 4;
    localparam int PosW      = 2;
    localparam int SegW      = 7;
    localparam int DwellW    = 8;
    localparam int ValueW    = 16;
    localparam int RemW      = 14;
    localparam int DigitW    = 4;

    localparam logic [DwellW-1:0] DwellReset = 8'd5;
    localparam logic [ValueW-1:0] NumberMax  = 16'd9999;
    localparam logic [PosW-1:0]   LastPos    = 2'd3;

    localparam logic [SegW-1:0] SegBlank  = 7'h00;
    localparam logic [SegW-1:0] SegHyphen = 7'h01;

    localparam logic [2:0] OP_WRITE_DIGIT  = 3'd0;
    localparam logic [2:0] OP_WRITE_CHAR   = 3'd1;
    localparam logic [2:0] OP_WRITE_NUMBER = 3'd2;
    localparam logic [2:0] OP_SET_DOT      = 3'd3;
    localparam logic [2:0] OP_CLEAR_DOT    = 3'd4;
    localparam logic [2:0] OP_BLANK_DIGIT  = 3'd5;
    localparam logic [2:0] OP_CLEAR_ALL    = 3'd6;
    localparam logic [2:0] OP_TICK         = 3'd7;

    typedef struct packed {
        logic            accept;
        logic            conv_load;
        logic            conv_en;
        logic [PosW-1:0] conv_step;
    } ssd_cmd_t;

    typedef struct packed {
        logic start_conv;
        logic out_free;
    } ssd_sts_t;

    function automatic logic [SegW-1:0] dec_shape(input logic [DigitW-1:0] d);
        logic [SegW-1:0] s;
        case (d)
            4'd0:    s = 7'h7E;
            4'd1:    s = 7'h30;
            4'd2:    s = 7'h6D;
            4'd3:    s = 7'h79;
            4'd4:    s = 7'h33;
            4'd5:    s = 7'h5B;
            4'd6:    s = 7'h5F;
            4'd7:    s = 7'h70;
            4'd8:    s = 7'h7F;
            4'd9:    s = 7'h7B;
            default: s = SegBlank;
        endcase
        return s;
    endfunction

    function automatic logic [SegW-1:0] upper_shape(input logic [4:0] i);
        logic [SegW-1:0] s;
        case (i)
            5'd0:    s = 7'h77;
            5'd2:    s = 7'h4E;
            5'd4:    s = 7'h4F;
            5'd5:    s = 7'h47;
            5'd6:    s = 7'h5E;
            5'd7:    s = 7'h37;
            5'd8:    s = 7'h06;
            5'd9:    s = 7'h3C;
            5'd11:   s = 7'h0E;
            5'd14:   s = 7'h7E;
            5'd15:   s = 7'h67;
            5'd18:   s = 7'h5B;
            5'd20:   s = 7'h3E;
            5'd24:   s = 7'h3B;
            default: s = SegBlank;
        endcase
        return s;
    endfunction

    function automatic logic [SegW-1:0] lower_shape(input logic [4:0] i);
        logic [SegW-1:0] s;
        case (i)
            5'd0:    s = 7'h7D;
            5'd1:    s = 7'h1F;
            5'd2:    s = 7'h0D;
            5'd3:    s = 7'h3D;
            5'd4:    s = 7'h6F;
            5'd6:    s = 7'h7B;
            5'd7:    s = 7'h17;
            5'd8:    s = 7'h04;
            5'd9:    s = 7'h3C;
            5'd11:   s = 7'h30;
            5'd13:   s = 7'h15;
            5'd14:   s = 7'h1D;
            5'd15:   s = 7'h67;
            5'd16:   s = 7'h73;
            5'd17:   s = 7'h05;
            5'd18:   s = 7'h5B;
            5'd19:   s = 7'h0F;
            5'd20:   s = 7'h1C;
            5'd24:   s = 7'h3B;
            default: s = SegBlank;
        endcase
        return s;
    endfunction

    function automatic logic [SegW-1:0] char_shape(input logic [ValueW-1:0] c);
        logic [7:0]      lo;
        logic [7:0]      off_u;
        logic [7:0]      off_l;
        logic [SegW-1:0] s;
        lo    = c[7:0];
        off_u = lo - 8'h41;
        off_l = lo - 8'h61;
        if (c[15:8] != 8'h00)
            s = SegBlank;
        else if (lo >= 8'h30 && lo <= 8'h39)
            s = dec_shape(lo[3:0]);
        else if (lo >= 8'h41 && lo <= 8'h5A)
            s = upper_shape(off_u[4:0]);
        else if (lo >= 8'h61 && lo <= 8'h7A)
            s = lower_shape(off_l[4:0]);
        else if (lo == 8'h2D)
            s = SegHyphen;
        else
            s = SegBlank;
        return s;
    endfunction

    function automatic logic [RemW-1:0] place_weight(input logic [PosW-1:0] step);
        logic [RemW-1:0] w;
        case (step)
            2'd0:    w = 14'd1000;
            2'd1:    w = 14'd100;
            2'd2:    w = 14'd10;
            default: w = 14'd1;
        endcase
        return w;
    endfunction

endpackage

// ----- design/seven_segment_mux_display_controller.sv -----
// a tick that ends a dwell shows its item on m_axis in the cycle after it is taken
// one item per cycle, except a write number in range
// a write number in range holds s_axis_tready low while it converts, one decimal place a cycle
// s_axis_tready also waits while an output item is held and not taken
// reset (rst_n low, asynchronous) blanks all digits, clears dots, scan and dwell count,
// and sets dwell_ticks to 5
module seven_segment_mux_display_controller (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_data,       // dwell_ticks
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [2:0]  s_axis_tuser,   // operation
    input  logic [23:0] s_axis_tdata,   // position [1:0], value [17:2]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // select [1:0], segments [8:2], dot_on [9]
);

    ssd_pkg::ssd_cmd_t cmd;
    ssd_pkg::ssd_sts_t sts;

    ssd_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .sts           (sts),
        .cmd           (cmd)
    );

    ssd_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cmd           (cmd),
        .sts           (sts)
    );

endmodule

// ----- design/ssd_ctrl.sv -----
module ssd_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  ssd_pkg::ssd_sts_t  sts,
    output ssd_pkg::ssd_cmd_t  cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_CONV = 1'b1;

    logic                     state_reg;
    logic                     state_next;
    logic [ssd_pkg::PosW-1:0] step_reg;
    logic [ssd_pkg::PosW-1:0] step_next;
    logic                     accept;

    assign s_axis_tready = (state_reg == ST_IDLE) && sts.out_free;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && sts.start_conv)
                begin
                    state_next = ST_CONV;
                    step_next  = '0;
                end
            end
            ST_CONV:
            begin
                step_next = step_reg + 2'd1;
                if (step_reg == ssd_pkg::LastPos)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd.accept    = accept;
        cmd.conv_load = accept && sts.start_conv;
        cmd.conv_en   = (state_reg == ST_CONV);
        cmd.conv_step = step_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

`ifndef SYNTHESIS
    a_no_accept_in_conv: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CONV |-> !s_axis_tready)
        else $error("item taken during number conversion");

    a_conv_starts_at_msd: assert property (@(posedge clk) disable iff (!rst_n)
        accept && sts.start_conv |=> state_reg == ST_CONV && step_reg == '0)
        else $error("conversion did not start at the leading digit");

    a_conv_ends: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CONV && step_reg == ssd_pkg::LastPos |=> state_reg == ST_IDLE)
        else $error("conversion did not finish after the last digit");
`endif

endmodule

// ----- design/ssd_datapath.sv -----
module ssd_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [7:0]         cfg_data,
    input  logic [2:0]         s_axis_tuser,
    input  logic [23:0]        s_axis_tdata,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [15:0]        m_axis_tdata,
    input  ssd_pkg::ssd_cmd_t  cmd,
    output ssd_pkg::ssd_sts_t  sts
);

    logic [ssd_pkg::DwellW-1:0] dwell_ticks_reg;
    logic [ssd_pkg::SegW-1:0]   pattern_reg [ssd_pkg::NumDigits];
    logic                       dot_reg     [ssd_pkg::NumDigits];
    logic [ssd_pkg::PosW-1:0]   scan_reg;
    logic [ssd_pkg::DwellW-1:0] count_reg;
    logic [ssd_pkg::RemW-1:0]   rem_reg;
    logic                       seen_reg;
    logic                       out_valid_reg;
    logic [ssd_pkg::PosW-1:0]   out_select_reg;
    logic [ssd_pkg::SegW-1:0]   out_segments_reg;
    logic                       out_dot_reg;

    logic [2:0]                 op;
    logic [ssd_pkg::PosW-1:0]   pos;
    logic [ssd_pkg::ValueW-1:0] val;
    logic                       is_tick;
    logic [ssd_pkg::DwellW-1:0] limit;
    logic [ssd_pkg::DwellW-1:0] count_inc;
    logic                       emit;

    logic [ssd_pkg::RemW-1:0]   weight;
    logic [ssd_pkg::RemW-1:0]   mult [10];
    logic [8:0]                 ge;
    logic [ssd_pkg::DigitW-1:0] digit;
    logic [ssd_pkg::SegW-1:0]   conv_shape;

    assign op  = s_axis_tuser;
    assign pos = s_axis_tdata[1:0];
    assign val = s_axis_tdata[17:2];

    assign is_tick   = (op == ssd_pkg::OP_TICK);
    assign limit     = (dwell_ticks_reg == '0) ? 8'd1 : dwell_ticks_reg;
    assign count_inc = count_reg + 8'd1;
    assign emit      = cmd.accept && is_tick && ((count_inc == '0) || (count_inc >= limit));

    assign sts.start_conv = (op == ssd_pkg::OP_WRITE_NUMBER) && (val <= ssd_pkg::NumberMax);
    assign sts.out_free   = !out_valid_reg || m_axis_tready;

    // one decimal place per cycle: compare against the nine multiples
    assign weight = ssd_pkg::place_weight(cmd.conv_step);

    always_comb
    begin
        for (int k = 0; k < 10; k++)
        begin
            mult[k] = ssd_pkg::RemW'(weight * ssd_pkg::RemW'(k));
        end
        for (int k = 1; k < 10; k++)
        begin
            ge[k-1] = (rem_reg >= mult[k]);
        end
        digit = ssd_pkg::DigitW'($countones(ge));
        if (digit == '0 && !seen_reg && cmd.conv_step != ssd_pkg::LastPos)
            conv_shape = ssd_pkg::SegBlank;
        else
            conv_shape = ssd_pkg::dec_shape(digit);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dwell_ticks_reg <= ssd_pkg::DwellReset;
            for (int i = 0; i < ssd_pkg::NumDigits; i++)
            begin
                pattern_reg[i] <= ssd_pkg::SegBlank;
                dot_reg[i]     <= 1'b0;
            end
            scan_reg      <= '0;
            count_reg     <= '0;
            rem_reg       <= '0;
            seen_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                dwell_ticks_reg <= cfg_data;
            end

            if (cmd.accept)
            begin
                case (op)
                    ssd_pkg::OP_WRITE_DIGIT:
                    begin
                        pattern_reg[pos] <= (val <= 16'd9) ?
                            ssd_pkg::dec_shape(val[3:0]) : ssd_pkg::SegBlank;
                    end
                    ssd_pkg::OP_WRITE_CHAR:
                    begin
                        pattern_reg[pos] <= ssd_pkg::char_shape(val);
                    end
                    ssd_pkg::OP_WRITE_NUMBER:
                    begin
                        if (cmd.conv_load)
                        begin
                            rem_reg  <= val[ssd_pkg::RemW-1:0];
                            seen_reg <= 1'b0;
                        end
                        else
                        begin
                            for (int i = 0; i < ssd_pkg::NumDigits; i++)
                            begin
                                pattern_reg[i] <= ssd_pkg::SegBlank;
                                dot_reg[i]     <= 1'b0;
                            end
                        end
                    end
                    ssd_pkg::OP_SET_DOT:
                    begin
                        dot_reg[pos] <= 1'b1;
                    end
                    ssd_pkg::OP_CLEAR_DOT:
                    begin
                        dot_reg[pos] <= 1'b0;
                    end
                    ssd_pkg::OP_BLANK_DIGIT:
                    begin
                        pattern_reg[pos] <= ssd_pkg::SegBlank;
                    end
                    ssd_pkg::OP_CLEAR_ALL:
                    begin
                        for (int i = 0; i < ssd_pkg::NumDigits; i++)
                        begin
                            pattern_reg[i] <= ssd_pkg::SegBlank;
                            dot_reg[i]     <= 1'b0;
                        end
                    end
                    default:
                    begin
                        count_reg <= emit ? '0 : count_inc;
                        if (emit)
                        begin
                            scan_reg <= scan_reg + 2'd1;
                        end
                    end
                endcase
            end

            if (cmd.conv_en)
            begin
                pattern_reg[cmd.conv_step] <= conv_shape;
                rem_reg                    <= rem_reg - mult[digit];
                seen_reg                   <= seen_reg || (digit != '0);
            end

            if (emit)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_select_reg   <= scan_reg;
            out_segments_reg <= pattern_reg[scan_reg];
            out_dot_reg      <= dot_reg[scan_reg];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'b0, out_dot_reg, out_segments_reg, out_select_reg};

endmodule

// ----- tb/tb.sv -----
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [2:0]                 op;
        logic [ssd_pkg::PosW-1:0]   pos;
        logic [ssd_pkg::ValueW-1:0] value;
    } disp_cmd_t;

    typedef struct packed {
        logic [ssd_pkg::PosW-1:0] sel;
        logic [ssd_pkg::SegW-1:0] seg;
        logic                     dot;
    } scan_frame_t;

    logic        clk;
    logic        rst_n         = 1'b0;
    logic        cfg_we        = 1'b0;
    logic [7:0]  cfg_data      = 8'd0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [2:0]  s_axis_tuser  = 3'd0;
    logic [23:0] s_axis_tdata  = 24'd0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;

    seven_segment_mux_display_controller u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // glyph tables, segment a at bit 6
    logic [ssd_pkg::SegW-1:0] digit_glyph [0:9] = '{
        7'h7E, 7'h30, 7'h6D, 7'h79, 7'h33, 7'h5B, 7'h5F, 7'h70, 7'h7F, 7'h7B
    };
    logic [ssd_pkg::SegW-1:0] upper_glyph [0:25] = '{
        7'h77, 7'h00, 7'h4E, 7'h00, 7'h4F, 7'h47, 7'h5E, 7'h37, 7'h06, 7'h3C,
        7'h00, 7'h0E, 7'h00, 7'h00, 7'h7E, 7'h67, 7'h00, 7'h00, 7'h5B, 7'h00,
        7'h3E, 7'h00, 7'h00, 7'h00, 7'h3B, 7'h00
    };
    logic [ssd_pkg::SegW-1:0] lower_glyph [0:25] = '{
        7'h7D, 7'h1F, 7'h0D, 7'h3D, 7'h6F, 7'h00, 7'h7B, 7'h17, 7'h04, 7'h3C,
        7'h00, 7'h30, 7'h00, 7'h15, 7'h1D, 7'h67, 7'h73, 7'h05, 7'h5B, 7'h0F,
        7'h1C, 7'h00, 7'h00, 7'h00, 7'h3B, 7'h00
    };

    // display state as the block should hold it
    logic [ssd_pkg::SegW-1:0]   shown_seg [0:3];
    logic                       shown_dot [0:3];
    logic [ssd_pkg::PosW-1:0]   scan_pos;
    logic [ssd_pkg::DwellW-1:0] dwell_cnt;
    logic [ssd_pkg::DwellW-1:0] dwell_ticks;

    disp_cmd_t   cmd_queue[$];
    scan_frame_t frames_due[$];
    int unsigned cmds_issued   = 0;
    int unsigned cmds_accepted = 0;
    int unsigned error_count   = 0;

    function automatic logic [ssd_pkg::SegW-1:0] glyph_for_char(
        input logic [ssd_pkg::ValueW-1:0] c);
        if (c >= 16'h30 && c <= 16'h39)
            return digit_glyph[c - 16'h30];
        if (c >= 16'h41 && c <= 16'h5A)
            return upper_glyph[c - 16'h41];
        if (c >= 16'h61 && c <= 16'h7A)
            return lower_glyph[c - 16'h61];
        if (c == 16'h2D)
            return ssd_pkg::SegHyphen;
        return ssd_pkg::SegBlank;
    endfunction

    task automatic clear_display();
        for (int i = 0; i < ssd_pkg::NumDigits; i++)
        begin
            shown_seg[i] = ssd_pkg::SegBlank;
            shown_dot[i] = 1'b0;
        end
    endtask

    task automatic show_number(input logic [ssd_pkg::ValueW-1:0] v);
        int unsigned weight [4] = '{1000, 100, 10, 1};
        int unsigned q;
        if (v > 16'd9999)
        begin
            clear_display();
            return;
        end
        for (int i = 0; i < ssd_pkg::NumDigits; i++)
        begin
            q = v / weight[i];
            if (q == 0 && i < ssd_pkg::NumDigits - 1)
                shown_seg[i] = ssd_pkg::SegBlank;
            else
                shown_seg[i] = digit_glyph[q % 10];
        end
    endtask

    task automatic apply_display_cmd(input disp_cmd_t c);
        logic [ssd_pkg::DwellW-1:0] limit;
        scan_frame_t                f;
        case (c.op)
            ssd_pkg::OP_WRITE_DIGIT:
            begin
                shown_seg[c.pos] = (c.value <= 9) ? digit_glyph[c.value] : ssd_pkg::SegBlank;
            end
            ssd_pkg::OP_WRITE_CHAR:   shown_seg[c.pos] = glyph_for_char(c.value);
            ssd_pkg::OP_WRITE_NUMBER: show_number(c.value);
            ssd_pkg::OP_SET_DOT:      shown_dot[c.pos] = 1'b1;
            ssd_pkg::OP_CLEAR_DOT:    shown_dot[c.pos] = 1'b0;
            ssd_pkg::OP_BLANK_DIGIT:  shown_seg[c.pos] = ssd_pkg::SegBlank;
            ssd_pkg::OP_CLEAR_ALL:    clear_display();
            default:
            begin
                limit     = (dwell_ticks == 0) ? 8'd1 : dwell_ticks;
                dwell_cnt = dwell_cnt + 8'd1;
                if (dwell_cnt == 0 || dwell_cnt >= limit)
                begin
                    dwell_cnt = '0;
                    f.sel     = scan_pos;
                    f.seg     = shown_seg[scan_pos];
                    f.dot     = shown_dot[scan_pos];
                    frames_due.push_back(f);
                    scan_pos  = scan_pos + 2'd1;
                end
            end
        endcase
    endtask

    task automatic queue_cmd(input logic [2:0] op, input logic [ssd_pkg::PosW-1:0] pos,
                             input logic [ssd_pkg::ValueW-1:0] value);
        disp_cmd_t c;
        c.op    = op;
        c.pos   = pos;
        c.value = value;
        cmd_queue.push_back(c);
        cmds_issued++;
    endtask

    function automatic disp_cmd_t random_cmd(input int unsigned tick_pct);
        disp_cmd_t c;
        c.pos   = ssd_pkg::PosW'($urandom_range(0, 3));
        c.value = ssd_pkg::ValueW'($urandom);
        if ($urandom_range(0, 99) < tick_pct)
        begin
            c.op = ssd_pkg::OP_TICK;
            return c;
        end
        c.op = 3'($urandom_range(0, 6));
        case (c.op)
            ssd_pkg::OP_WRITE_DIGIT:
                case ($urandom_range(0, 3))
                    0, 1:    c.value = ssd_pkg::ValueW'($urandom_range(0, 9));
                    2:       c.value = ssd_pkg::ValueW'($urandom_range(10, 15));
                    default: ;
                endcase
            ssd_pkg::OP_WRITE_CHAR:
                case ($urandom_range(0, 5))
                    0:       c.value = ssd_pkg::ValueW'($urandom_range(16'h30, 16'h39));
                    1:       c.value = ssd_pkg::ValueW'($urandom_range(16'h41, 16'h5A));
                    2:       c.value = ssd_pkg::ValueW'($urandom_range(16'h61, 16'h7A));
                    3:       c.value = 16'h2D;
                    4:       c.value = ssd_pkg::ValueW'($urandom_range(0, 255));
                    default: ;
                endcase
            ssd_pkg::OP_WRITE_NUMBER:
                case ($urandom_range(0, 4))
                    0:       c.value = ssd_pkg::ValueW'($urandom_range(0, 9));
                    1:       c.value = ssd_pkg::ValueW'($urandom_range(10, 999));
                    2:       c.value = ssd_pkg::ValueW'($urandom_range(1000, 9999));
                    3:       c.value = ssd_pkg::ValueW'($urandom_range(10000, 65535));
                    default: c.value = ssd_pkg::ValueW'($urandom_range(0, 9999));
                endcase
            default: ;
        endcase
        return c;
    endfunction

    task automatic wait_idle();
        while (!(cmds_accepted == cmds_issued && frames_due.size() == 0))
            @(posedge clk);
        // a number write keeps the block busy with nothing to show while it converts
        repeat (8) @(posedge clk);
    endtask

    task automatic write_dwell(input logic [7:0] v);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        dwell_ticks = v;
        cfg_we      <= 1'b0;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("[seven_segment_mux_display_controller] ERROR");
        $finish;
    end

    // item sender: bursts of random length with random gaps
    int unsigned burst_left = 1;
    int unsigned gap_left   = 0;

    always @(posedge clk)
    begin
        disp_cmd_t sent;
        disp_cmd_t nxt;
        logic      valid_next;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                sent.op    = s_axis_tuser;
                sent.pos   = s_axis_tdata[1:0];
                sent.value = s_axis_tdata[17:2];
                apply_display_cmd(sent);
                cmds_accepted++;
            end
            if (!(s_axis_tvalid && !s_axis_tready))
            begin
                valid_next = 1'b0;
                if (gap_left > 0)
                    gap_left--;
                else if (cmd_queue.size() > 0)
                begin
                    nxt        = cmd_queue.pop_front();
                    valid_next = 1'b1;
                    s_axis_tuser <= nxt.op;
                    s_axis_tdata <= {6'd0, nxt.value, nxt.pos};
                    burst_left--;
                    if (burst_left == 0)
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                s_axis_tvalid <= valid_next;
            end
        end
    end

    // result receiver with its own stall pattern
    int unsigned stall_mode  = 0;
    int unsigned mode_cycles = 0;

    always @(posedge clk)
    begin
        scan_frame_t want;
        scan_frame_t got;
        logic        ready_next;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.sel = m_axis_tdata[1:0];
                got.seg = m_axis_tdata[8:2];
                got.dot = m_axis_tdata[9];
                if (frames_due.size() == 0)
                begin
                    $display("%0t: unexpected item select=%0d segments=%h dot=%b",
                             $time, got.sel, got.seg, got.dot);
                    error_count++;
                end
                else
                begin
                    want = frames_due.pop_front();
                    if (got.sel !== want.sel)
                    begin
                        $display("%0t: select expected %0d actual %0d", $time, want.sel, got.sel);
                        error_count++;
                    end
                    if (got.seg !== want.seg)
                    begin
                        $display("%0t: segments expected %h actual %h", $time, want.seg, got.seg);
                        error_count++;
                    end
                    if (got.dot !== want.dot)
                    begin
                        $display("%0t: dot_on expected %b actual %b", $time, want.dot, got.dot);
                        error_count++;
                    end
                end
            end
            if (mode_cycles == 0)
            begin
                stall_mode  = $urandom_range(0, 2);
                mode_cycles = $urandom_range(20, 80);
            end
            mode_cycles--;
            case (stall_mode)
                0:       ready_next = 1'b1;
                1:       ready_next = 1'($urandom_range(0, 1));
                default: ready_next = ($urandom_range(0, 4) == 0);
            endcase
            m_axis_tready <= ready_next;
        end
    end

    int unsigned dwell_plan [8] = '{0, 3, 255, 2, 10, 4, 1, 0};
    int unsigned size_plan  [8] = '{160, 160, 300, 160, 160, 160, 160, 160};

    initial
    begin
        int unsigned dw;
        int unsigned tick_pct;
        int unsigned spins;
        dwell_ticks = ssd_pkg::DwellReset;
        dwell_cnt   = '0;
        scan_pos    = '0;
        clear_display();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset dwell of five
        queue_cmd(ssd_pkg::OP_WRITE_DIGIT, 2'd0, 16'd0);
        queue_cmd(ssd_pkg::OP_SET_DOT, 2'd0, 16'd0);
        repeat (5) queue_cmd(ssd_pkg::OP_TICK, 2'd0, 16'hFFFF);
        wait_idle();

        write_dwell(8'd1);
        queue_cmd(ssd_pkg::OP_WRITE_DIGIT, 2'd1, 16'd9);
        queue_cmd(ssd_pkg::OP_WRITE_DIGIT, 2'd2, 16'd10);
        queue_cmd(ssd_pkg::OP_WRITE_DIGIT, 2'd3, 16'hFFFF);
        queue_cmd(ssd_pkg::OP_SET_DOT, 2'd3, 16'd0);
        repeat (4) queue_cmd(ssd_pkg::OP_TICK, 2'd3, 16'd0);
        queue_cmd(ssd_pkg::OP_WRITE_CHAR, 2'd0, 16'h2D);
        queue_cmd(ssd_pkg::OP_WRITE_CHAR, 2'd1, 16'h7A);
        queue_cmd(ssd_pkg::OP_WRITE_CHAR, 2'd2, 16'h41);
        queue_cmd(ssd_pkg::OP_WRITE_CHAR, 2'd3, 16'h0141);
        queue_cmd(ssd_pkg::OP_CLEAR_DOT, 2'd0, 16'd0);
        repeat (2) queue_cmd(ssd_pkg::OP_TICK, 2'd1, 16'd0);
        queue_cmd(ssd_pkg::OP_WRITE_NUMBER, 2'd3, 16'd9999);
        repeat (2) queue_cmd(ssd_pkg::OP_TICK, 2'd2, 16'd0);
        queue_cmd(ssd_pkg::OP_WRITE_NUMBER, 2'd0, 16'd0);
        queue_cmd(ssd_pkg::OP_BLANK_DIGIT, 2'd2, 16'd0);
        repeat (4) queue_cmd(ssd_pkg::OP_TICK, 2'd0, 16'd0);
        queue_cmd(ssd_pkg::OP_WRITE_NUMBER, 2'd1, 16'd10000);
        queue_cmd(ssd_pkg::OP_SET_DOT, 2'd1, 16'd0);
        queue_cmd(ssd_pkg::OP_CLEAR_ALL, 2'd2, 16'hFFFF);
        repeat (2) queue_cmd(ssd_pkg::OP_TICK, 2'd0, 16'd0);
        wait_idle();

        dwell_plan[7] = $urandom_range(5, 40);
        for (int p = 0; p < 8; p++)
        begin
            dw = dwell_plan[p];
            write_dwell(8'(dw));
            tick_pct = (dw > 100) ? 95 : 45;
            for (int n = 0; n < size_plan[p]; n++)
                cmd_queue.push_back(random_cmd(tick_pct));
            cmds_issued += size_plan[p];
            wait_idle();
        end

        spins = 0;
        while (frames_due.size() != 0 && spins < 1000)
        begin
            @(posedge clk);
            spins++;
        end
        repeat (10) @(posedge clk);
        if (frames_due.size() != 0)
        begin
            $display("%0t: %0d expected items never arrived", $time, frames_due.size());
            error_count++;
        end
        if (error_count == 0)
            $display("[seven_segment_mux_display_controller] OK");
        else
            $display("[seven_segment_mux_display_controller] ERROR");
        $finish;
    end

endmodule

// ----- seven_segment_mux_display_controller.f -----
design/ssd_pkg.sv
design/ssd_ctrl.sv
design/ssd_datapath.sv
design/seven_segment_mux_display_controller.sv
tb/tb.sv
